@@ hw/rtl/ddo_pkg.sv @@
`default_nettype none

package ddo_pkg;

   localparam int TAYLOR_TERMS = 6;
   localparam int SERIES_LEN   = (TAYLOR_TERMS < 2) ? 2 : ((TAYLOR_TERMS > 8) ? 8 : TAYLOR_TERMS);
   localparam int J_W          = 3;

   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int M_W     = 36;
   localparam int SUM_W   = 40;
   localparam int KDIV_W  = 4;
   localparam int REM_W   = 3;

   localparam int DIV_STEP    = 6;
   localparam int DIV_CYCLES  = M_W / DIV_STEP;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_METERS_PER_TICK    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_WHEEL_BASE = 4'd1;

   localparam logic [23:0]    IWB_RESET = 24'd65536;
   localparam logic [M_W-1:0] Q28_ONE   = 36'd268435456;

   localparam logic [PROD_W-1:0] POS_LIMIT = 66'h7FFF_FFFF;
   localparam logic [PROD_W-1:0] NEG_LIMIT = 66'h8000_0000;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_travel;
      logic signed [31:0] right_travel;
      logic signed [31:0] robot_dx;
      logic signed [31:0] robot_dy;
      logic signed [31:0] robot_dtheta;
      logic [15:0]        sequence_res;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [KDIV_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic           done;
      logic [M_W-1:0] quotient;
   } div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ABS,
      ST_TRAV_L,
      ST_TRAV_R,
      ST_DIFF,
      ST_SUMS,
      ST_THETA,
      ST_THETA_DONE,
      ST_SER_START,
      ST_SER_DIV,
      ST_SER_MUL,
      ST_SER_ACC,
      ST_SER_ADD,
      ST_CLAMP,
      ST_DX,
      ST_DY,
      ST_DY_WB,
      ST_OUT
   } state_type;

   function automatic logic [PROD_W-1:0] rnd_shift(input logic [PROD_W-1:0] p, input int sh);
      logic [PROD_W-1:0] half;
      half = {{(PROD_W-1){1'b0}}, 1'b1} << (sh - 1);
      return (p + half) >> sh;
   endfunction

   function automatic logic [31:0] mag_clip(input logic [PROD_W-1:0] mag, input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (mag >= NEG_LIMIT) ? 32'h8000_0000 : mag[31:0];
      end else begin
         r = (mag > POS_LIMIT) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
      return neg ? (32'd0 - mag) : mag;
   endfunction

   function automatic logic [31:0] sum_clip(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] negv;
      logic [31:0]      r;
      negv = {SUM_W{1'b0}} - v;
      if (v > 40'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else if (v[SUM_W-1]) begin
         r = negv[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/diff_drive_odometry_step_unit.sv @@
// The response beat becomes valid after the accepted request beat has passed through the
// travel, theta, series, clamp and position states. A new request is accepted only in idle,
// which is re-entered once the result is loaded into the response register. Each series term
// goes through the small-divisor divider, then the shared 33 x 33 multiplier and the accumulator.
// Reset clears the previous counts, the sequence counter and both CSR registers to defaults.
`default_nettype none

module diff_drive_odometry_step_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire ddo_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output ddo_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ddo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                         csr_data
);

   ddo_pkg::state_type state_ff;
   ddo_pkg::state_type state_in;

   logic [31:0] mpt_ff;
   logic [23:0] iwb_ff;
   logic [31:0] prev_l_ff;
   logic [31:0] prev_r_ff;
   logic [15:0] seq_ff;

   logic [31:0] dl_ff;
   logic [31:0] dr_ff;
   logic [31:0] mag_l_ff;
   logic [31:0] mag_r_ff;
   logic        neg_l_ff;
   logic        neg_r_ff;
   logic [31:0] lt_ff;
   logic [31:0] rt_ff;

   logic [32:0]        dm_mag_ff;
   logic               dm_neg_ff;
   logic signed [32:0] dp_ff;
   logic [32:0]        dp_mag_ff;
   logic               dp_neg_ff;
   logic [31:0]        th_ff;
   logic [31:0]        ath_ff;

   logic [ddo_pkg::M_W-1:0]          m_ff;
   logic signed [ddo_pkg::SUM_W-1:0] s_ff;
   logic signed [ddo_pkg::SUM_W-1:0] c_ff;
   logic [ddo_pkg::J_W-1:0]          j_ff;
   logic [31:0]                      s_mag_ff;
   logic [31:0]                      c_mag_ff;
   logic                             s_neg_ff;
   logic                             c_neg_ff;
   logic [31:0]                      dx_ff;
   logic [31:0]                      dy_ff;

   ddo_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic             rsp_load;

   logic [ddo_pkg::MUL_W-1:0]  mul_a;
   logic [ddo_pkg::MUL_W-1:0]  mul_b;
   logic [ddo_pkg::PROD_W-1:0] mul_p;

   ddo_pkg::div_ctl_type  div_ctl;
   ddo_pkg::div_stat_type div_stat;

   logic [ddo_pkg::PROD_W-1:0] trav_round;
   logic [ddo_pkg::PROD_W-1:0] theta_round;
   logic [ddo_pkg::PROD_W-1:0] ser_round;
   logic [ddo_pkg::PROD_W-1:0] pos_round;
   logic [31:0]                trav_l_clip;
   logic [31:0]                trav_r_clip;
   logic [31:0]                theta_clip;
   logic [32:0]                dp_neg_val;
   logic signed [32:0]         lt_ext;
   logic signed [32:0]         rt_ext;
   logic signed [ddo_pkg::SUM_W-1:0] term;
   logic                       term_neg;
   logic                       ser_last;

   ddo_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (m_ff),
      .stat     (div_stat)
   );

   assign ser_last = (j_ff == ddo_pkg::J_W'(ddo_pkg::SERIES_LEN - 1));
   assign rsp_load = (state_ff == ddo_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddo_pkg::ST_IDLE:       if (req_valid) state_in = ddo_pkg::ST_ABS;
         ddo_pkg::ST_ABS:        state_in = ddo_pkg::ST_TRAV_L;
         ddo_pkg::ST_TRAV_L:     state_in = ddo_pkg::ST_TRAV_R;
         ddo_pkg::ST_TRAV_R:     state_in = ddo_pkg::ST_DIFF;
         ddo_pkg::ST_DIFF:       state_in = ddo_pkg::ST_SUMS;
         ddo_pkg::ST_SUMS:       state_in = ddo_pkg::ST_THETA;
         ddo_pkg::ST_THETA:      state_in = ddo_pkg::ST_THETA_DONE;
         ddo_pkg::ST_THETA_DONE: state_in = ddo_pkg::ST_SER_START;
         ddo_pkg::ST_SER_START:  state_in = ddo_pkg::ST_SER_DIV;
         ddo_pkg::ST_SER_DIV:    if (div_stat.done) state_in = ddo_pkg::ST_SER_MUL;
         ddo_pkg::ST_SER_MUL:    state_in = ddo_pkg::ST_SER_ACC;
         ddo_pkg::ST_SER_ACC:    state_in = ddo_pkg::ST_SER_ADD;
         ddo_pkg::ST_SER_ADD: begin
            state_in = ser_last ? ddo_pkg::ST_CLAMP : ddo_pkg::ST_SER_DIV;
         end
         ddo_pkg::ST_CLAMP:      state_in = ddo_pkg::ST_DX;
         ddo_pkg::ST_DX:         state_in = ddo_pkg::ST_DY;
         ddo_pkg::ST_DY:         state_in = ddo_pkg::ST_DY_WB;
         ddo_pkg::ST_DY_WB:      state_in = ddo_pkg::ST_OUT;
         ddo_pkg::ST_OUT:        if (!rsp_valid_ff || rsp_ready) state_in = ddo_pkg::ST_IDLE;
         default:                state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      div_ctl.start   = 1'b0;
      div_ctl.divisor = ddo_pkg::KDIV_W'(j_ff) + ddo_pkg::KDIV_W'(1);
      case (state_ff)
         ddo_pkg::ST_IDLE: req_ready = 1'b1;
         ddo_pkg::ST_TRAV_L: begin
            mul_a = {1'b0, mag_l_ff};
            mul_b = {1'b0, mpt_ff};
         end
         ddo_pkg::ST_TRAV_R: begin
            mul_a = {1'b0, mag_r_ff};
            mul_b = {1'b0, mpt_ff};
         end
         ddo_pkg::ST_THETA: begin
            mul_a = dm_mag_ff;
            mul_b = {9'd0, iwb_ff};
         end
         ddo_pkg::ST_SER_START: div_ctl.start = 1'b1;
         ddo_pkg::ST_SER_MUL: begin
            mul_a = div_stat.quotient[ddo_pkg::MUL_W-1:0];
            mul_b = {1'b0, ath_ff};
         end
         ddo_pkg::ST_SER_ADD: begin
            div_ctl.start   = !ser_last;
            div_ctl.divisor = ddo_pkg::KDIV_W'(j_ff) + ddo_pkg::KDIV_W'(2);
         end
         ddo_pkg::ST_DX: begin
            mul_a = dp_mag_ff;
            mul_b = {1'b0, s_mag_ff};
         end
         ddo_pkg::ST_DY: begin
            mul_a = dp_mag_ff;
            mul_b = {1'b0, c_mag_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      trav_round  = ddo_pkg::rnd_shift(mul_p, 16);
      theta_round = ddo_pkg::rnd_shift(mul_p, 4);
      ser_round   = ddo_pkg::rnd_shift(mul_p, 28);
      pos_round   = ddo_pkg::rnd_shift(mul_p, 29);
      trav_l_clip = ddo_pkg::mag_clip(trav_round, neg_l_ff);
      trav_r_clip = ddo_pkg::mag_clip(trav_round, neg_r_ff);
      theta_clip  = ddo_pkg::mag_clip(theta_round, dm_neg_ff);
      lt_ext      = {lt_ff[31], lt_ff};
      rt_ext      = {rt_ff[31], rt_ff};
      dp_neg_val  = 33'd0 - dp_ff;
      term        = ddo_pkg::SUM_W'(m_ff);
      term_neg    = j_ff[1] ^ (dm_neg_ff & j_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         seq_ff       <= '0;
         mpt_ff       <= '0;
         iwb_ff       <= ddo_pkg::IWB_RESET;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_valid && req_ready) begin
            prev_l_ff <= req_data.left_count;
            prev_r_ff <= req_data.right_count;
            seq_ff    <= seq_ff + 16'd1;
         end
         if (csr_valid) begin
            case (csr_index)
               ddo_pkg::CSR_METERS_PER_TICK:    mpt_ff <= csr_data;
               ddo_pkg::CSR_INVERSE_WHEEL_BASE: iwb_ff <= csr_data[23:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            dl_ff <= req_data.left_count - prev_l_ff;
            dr_ff <= req_data.right_count - prev_r_ff;
         end
         ddo_pkg::ST_ABS: begin
            neg_l_ff <= dl_ff[31];
            neg_r_ff <= dr_ff[31];
            mag_l_ff <= dl_ff[31] ? (32'd0 - dl_ff) : dl_ff;
            mag_r_ff <= dr_ff[31] ? (32'd0 - dr_ff) : dr_ff;
         end
         ddo_pkg::ST_TRAV_R: lt_ff <= ddo_pkg::apply_sign(trav_l_clip, neg_l_ff);
         ddo_pkg::ST_DIFF:   rt_ff <= ddo_pkg::apply_sign(trav_r_clip, neg_r_ff);
         ddo_pkg::ST_SUMS: begin
            dm_neg_ff <= rt_ext < lt_ext;
            dm_mag_ff <= (rt_ext < lt_ext) ? 33'(lt_ext - rt_ext) : 33'(rt_ext - lt_ext);
            dp_ff     <= rt_ext + lt_ext;
         end
         ddo_pkg::ST_THETA: begin
            dp_neg_ff <= dp_ff[32];
            dp_mag_ff <= dp_ff[32] ? dp_neg_val : dp_ff;
         end
         ddo_pkg::ST_THETA_DONE: begin
            ath_ff <= theta_clip;
            th_ff  <= ddo_pkg::apply_sign(theta_clip, dm_neg_ff);
            m_ff   <= ddo_pkg::Q28_ONE;
            s_ff   <= ddo_pkg::SUM_W'(ddo_pkg::Q28_ONE);
            c_ff   <= '0;
            j_ff   <= ddo_pkg::J_W'(1);
         end
         ddo_pkg::ST_SER_ACC: m_ff <= ser_round[ddo_pkg::M_W-1:0];
         ddo_pkg::ST_SER_ADD: begin
            if (j_ff[0]) begin
               c_ff <= term_neg ? (c_ff - term) : (c_ff + term);
            end else begin
               s_ff <= term_neg ? (s_ff - term) : (s_ff + term);
            end
            if (!ser_last) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         ddo_pkg::ST_CLAMP: begin
            s_mag_ff <= ddo_pkg::sum_clip(s_ff);
            c_mag_ff <= ddo_pkg::sum_clip(c_ff);
            s_neg_ff <= s_ff[ddo_pkg::SUM_W-1];
            c_neg_ff <= c_ff[ddo_pkg::SUM_W-1];
         end
         ddo_pkg::ST_DY: begin
            dx_ff <= ddo_pkg::apply_sign(ddo_pkg::mag_clip(pos_round, dp_neg_ff ^ s_neg_ff),
                                         dp_neg_ff ^ s_neg_ff);
         end
         ddo_pkg::ST_DY_WB: begin
            dy_ff <= ddo_pkg::apply_sign(ddo_pkg::mag_clip(pos_round, dp_neg_ff ^ c_neg_ff),
                                         dp_neg_ff ^ c_neg_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.left_travel  <= lt_ff;
         rsp_ff.right_travel <= rt_ff;
         rsp_ff.robot_dx     <= dx_ff;
         rsp_ff.robot_dy     <= dy_ff;
         rsp_ff.robot_dtheta <= th_ff;
         rsp_ff.sequence_res <= seq_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

@@ hw/rtl/ddo_mul.sv @@
`default_nettype none

module ddo_mul (
   input  wire logic                           clock,
   input  wire logic [ddo_pkg::MUL_W-1:0]      a,
   input  wire logic [ddo_pkg::MUL_W-1:0]      b,
   output logic      [ddo_pkg::PROD_W-1:0]     product
);

   logic [ddo_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= ddo_pkg::PROD_W'(a) * ddo_pkg::PROD_W'(b);
   end

   assign product = product_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ddo_div.sv @@
`default_nettype none

module ddo_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ddo_pkg::div_ctl_type         ctl,
   input  wire logic [ddo_pkg::M_W-1:0]      dividend,
   output ddo_pkg::div_stat_type             stat
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [ddo_pkg::DIV_CNT_W-1:0]    count_ff;
   logic [ddo_pkg::REM_W-1:0]        rem_ff;
   logic [ddo_pkg::REM_W-1:0]        rem_in;
   logic [ddo_pkg::M_W-1:0]          work_ff;
   logic [ddo_pkg::M_W-1:0]          work_in;
   logic [ddo_pkg::KDIV_W-1:0]       divisor_ff;
   logic [ddo_pkg::KDIV_W-1:0]       trial;

   always_comb begin
      rem_in  = rem_ff;
      work_in = work_ff;
      trial   = '0;
      for (int i = 0; i < ddo_pkg::DIV_STEP; i++) begin
         trial   = {rem_in, work_in[ddo_pkg::M_W-1]};
         work_in = {work_in[ddo_pkg::M_W-2:0], 1'b0};
         if (trial >= divisor_ff) begin
            trial      = trial - divisor_ff;
            work_in[0] = 1'b1;
         end
         rem_in = trial[ddo_pkg::REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         work_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= ctl.divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = work_ff;

endmodule

`default_nettype wire
